/* rtl/core/crypt_table_string_hash_top_defines.svh */
// Assertion macros for the string hash block and its checker.
// Each macro clocks on aclk and is disabled while aresetn is low.
`ifndef CRYPT_TABLE_STRING_HASH_TOP_DEFINES_SVH
`define CRYPT_TABLE_STRING_HASH_TOP_DEFINES_SVH

// Same-cycle implication.
`define CTHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cths_pkg.sv */
package cths_pkg;

    // number of 256-word groups kept in the crypt ROM (1..5)
    localparam int TABLE_GROUPS = 5;

    localparam int GROUP_WORDS  = 256;
    localparam int ALL_GROUPS   = 5;
    localparam int TABLE_WORDS  = TABLE_GROUPS * GROUP_WORDS;
    localparam int ADDR_W       = $clog2(TABLE_WORDS);

    localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
    localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
    localparam logic [31:0] GEN_SEED_INIT = 32'h00100001;
    localparam logic [31:0] GEN_MUL       = 32'd125;
    localparam logic [31:0] GEN_ADD       = 32'd3;
    localparam logic [31:0] GEN_MOD       = 32'h002AAAAB;
    localparam logic [31:0] SEED_TWO_ADD  = 32'd3;

    typedef logic [31:0] word_arr_t [TABLE_WORDS];

    // stage-1 control: one beat whose ROM word has been read
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] ch;
    } cths_ctl_t;

    function automatic logic [31:0] gen_next(input logic [31:0] s);
        return (s * GEN_MUL + GEN_ADD) % GEN_MOD;
    endfunction

    // generator walks column-major over all five groups; only kept groups are stored
    function automatic word_arr_t build_crypt();
        word_arr_t   t;
        logic [31:0] s;
        logic [31:0] hi;
        s = GEN_SEED_INIT;
        for (int col = 0; col < GROUP_WORDS; col++) begin
            for (int grp = 0; grp < ALL_GROUPS; grp++) begin
                s  = gen_next(s);
                hi = s;
                s  = gen_next(s);
                if (grp < TABLE_GROUPS) begin
                    t[grp * GROUP_WORDS + col] = {hi[15:0], s[15:0]};
                end
            end
        end
        return t;
    endfunction

endpackage

/* rtl/core/cths_rom.sv */
module cths_rom (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [cths_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]               rd_data
);

    localparam cths_pkg::word_arr_t CRYPT_ROM = cths_pkg::build_crypt();

    logic [31:0] rd_data_reg;

    // read data held while stage 1 is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= CRYPT_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/cths_mix.sv */
module cths_mix (
    input  logic                aclk,
    input  logic                aresetn,
    input  cths_pkg::cths_ctl_t ctl,
    input  logic [31:0]         crypt_word,
    output logic                fire,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    logic [31:0] seed_one_reg;
    logic [31:0] seed_one_next;
    logic [31:0] seed_two_reg;
    logic [31:0] seed_two_next;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [31:0] mix_one;
    logic [31:0] mix_two;

    assign mix_one = crypt_word ^ (seed_one_reg + seed_two_reg);
    assign mix_two = {24'd0, ctl.ch} + mix_one + seed_two_reg
                     + {seed_two_reg[26:0], 5'd0} + cths_pkg::SEED_TWO_ADD;

    // only a last beat needs room in the output register
    assign fire = ctl.valid && (!ctl.last || !m_tvalid_reg || m_tready);

    always_comb begin
        seed_one_next = seed_one_reg;
        seed_two_next = seed_two_reg;
        if (fire) begin
            if (ctl.last) begin
                seed_one_next = cths_pkg::SEED_ONE_INIT;
                seed_two_next = cths_pkg::SEED_TWO_INIT;
            end else begin
                seed_one_next = mix_one;
                seed_two_next = mix_two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_one_reg <= cths_pkg::SEED_ONE_INIT;
            seed_two_reg <= cths_pkg::SEED_TWO_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            seed_one_reg <= seed_one_next;
            seed_two_reg <= seed_two_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fire && ctl.last) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && ctl.last) begin
            m_tdata_reg <= mix_one;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/crypt_table_string_hash_top.sv */
// One-way string hash over a byte stream, crypt-table style. Each input beat
// carries one key byte (folded to ASCII upper case inside), a hash type that
// picks a 256-word group of the fixed crypt table (types above the last group
// use the last group) and tlast on the final byte of the key. The beat with
// tlast produces one output beat holding the 32-bit hash; the seeds then
// reload for the next key. Rate: one beat per clock sustained, but for the
// stall below. The ROM read address depends only on the byte and the type,
// so stage 0 reads the single-port crypt ROM and stage 1 mixes the word into
// the seeds. A last beat waits in stage 1 only while the output register
// still holds an untaken hash.
module crypt_table_string_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic [2:0]  s_tuser,   // [2:0] table_select
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);

    localparam logic [2:0] LAST_GROUP = 3'(cths_pkg::TABLE_GROUPS - 1);

    logic                        accept;
    logic                        fire;
    logic [7:0]                  ch_fold;
    logic [2:0]                  sel_sat;
    logic [cths_pkg::ADDR_W-1:0] rom_addr;
    logic [31:0]                 crypt_word;
    cths_pkg::cths_ctl_t         ctl_reg;
    cths_pkg::cths_ctl_t         ctl_next;

    // 'a'..'z' -> 'A'..'Z', everything else passes
    assign ch_fold = (s_tdata >= 8'h61 && s_tdata <= 8'h7A) ? s_tdata - 8'h20 : s_tdata;
    assign sel_sat = (s_tuser > LAST_GROUP) ? LAST_GROUP : s_tuser;
    // group * 256 + byte; the top bits drop away for fewer groups
    assign rom_addr = cths_pkg::ADDR_W'({sel_sat, ch_fold});

    // stage 1 frees up whenever its beat mixes in
    assign s_tready = !ctl_reg.valid || fire;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctl_next = ctl_reg;
        if (accept) begin
            ctl_next.valid = 1'b1;
            ctl_next.last  = s_tlast;
            ctl_next.ch    = ch_fold;
        end else if (fire) begin
            ctl_next.valid = 1'b0;
        end
    end

    // only the valid bit needs a reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else begin
            ctl_reg.valid <= ctl_next.valid;
        end
        ctl_reg.last <= ctl_next.last;
        ctl_reg.ch   <= ctl_next.ch;
    end

    cths_rom u_rom (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rom_addr),
        .rd_data (crypt_word)
    );

    cths_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl_reg),
        .crypt_word (crypt_word),
        .fire       (fire),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* rtl/core/cths_check.sv */
`include "crypt_table_string_hash_top_defines.svh"

module cths_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [2:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `CTHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed or dropped")
    `CTHS_ASSERT_NOW(a_ready_when_out_free, !m_tvalid, s_tready, "input stalled with output register empty")
    `CTHS_ASSERT_NEXT(a_last_gives_hash, (s_tvalid && s_tready && s_tlast && !m_tvalid) ##1 !m_tvalid, m_tvalid, "last beat gave no hash two cycles on")
    `CTHS_ASSERT_NEXT(a_mid_no_hash, (s_tvalid && s_tready && !s_tlast) ##1 !m_tvalid, !m_tvalid, "hash beat from a non-last byte")

endmodule

bind crypt_table_string_hash_top cths_check u_cths_check (.*);
